>>> rtl/core/two_wire_debug_bus_decoder_defines.svh
// Assertion macros for the two-wire debug bus decoder.
`ifndef TWO_WIRE_DEBUG_BUS_DECODER_DEFINES_SVH
`define TWO_WIRE_DEBUG_BUS_DECODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TWDB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TWDB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/twdb_pkg.sv
// Shared types and constants of the two-wire debug bus decoder.
package twdb_pkg;

  localparam int SPAN_W      = 48;
  localparam int LIMIT_W     = 16;
  localparam int BYTE_BITS   = 8;
  localparam int CODE_BITS   = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd40;

  typedef logic [SPAN_W-1:0] span_t;

  typedef enum logic [2:0] {
    KIND_START    = 3'd0,
    KIND_STOP     = 3'd1,
    KIND_INSTR    = 3'd2,
    KIND_LENGTH   = 3'd3,
    KIND_BYTE     = 3'd4,
    KIND_WAIT_END = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    OP_RD_DATA = 2'd0,
    OP_WR_DATA = 2'd1,
    OP_RD_ADDR = 2'd2,
    OP_WR_ADDR = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    PH_HUNT      = 4'd0,
    PH_SYNC      = 4'd1,
    PH_INS       = 4'd2,
    PH_LEN       = 4'd3,
    PH_RA_TURN   = 4'd4,
    PH_RBYTE     = 4'd5,
    PH_WBYTE     = 4'd6,
    PH_WAIT_TURN = 4'd7,
    PH_WAIT_POLL = 4'd8,
    PH_WAIT_DONE = 4'd9,
    PH_STOP_RISE = 4'd10
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  value;
    op_e         operation;
    span_t       first_sample;
    span_t       final_sample;
    logic        last;
  } result_t;

  // Up to two result words produced by one sample.
  typedef struct packed {
    logic [1:0] count;
    result_t    res_a;
    result_t    res_b;
  } push_t;

  typedef struct packed {
    logic              not_empty;
    logic              room;
    logic [QCNT_W-1:0] count;
  } queue_stat_t;

  // Truncate a 64-bit sample index to the reported span width.
  function automatic span_t to_span(logic [63:0] idx);
    return idx[SPAN_W-1:0];
  endfunction

endpackage

>>> rtl/core/twdb_if.sv
// Valid/ready channel interfaces for bus samples and decoded result words.
interface sample_if import twdb_pkg::*; ();
  logic valid;
  logic ready;
  logic clock_level;
  logic data_level;

  modport source (output valid, output clock_level, output data_level, input ready);
  modport sink   (input valid, input clock_level, input data_level, output ready);
endinterface

interface result_if import twdb_pkg::*; ();
  logic       valid;
  logic       ready;
  kind_e      kind;
  logic [7:0] value;
  op_e        operation;
  span_t      first_sample;
  span_t      final_sample;
  logic       last;

  modport source (output valid, output kind, output value, output operation,
                  output first_sample, output final_sample, output last, input ready);
  modport sink   (input valid, input kind, input value, input operation,
                  input first_sample, input final_sample, input last, output ready);
endinterface

>>> rtl/core/twdb_front.sv
// Front end: edge detection, packet phase tracking and result word generation.
module twdb_front
  import twdb_pkg::*;
#(
  parameter int COUNT_WIDTH = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  input  logic               clock_level_i,
  input  logic               data_level_i,
  input  logic [LIMIT_W-1:0] limit_i,
  output push_t              push_o
);

  logic [COUNT_WIDTH-1:0] now_q, low_start_q, low_start_d, field_start_q, field_start_d;
  logic [COUNT_WIDTH-1:0] pulse_len;
  logic                   prev_clk_q;
  phase_e                 phase_q, phase_d;
  logic                   daf_q, daf_d;
  logic [7:0]             shift_q, shift_d;
  logic [3:0]             bit_cnt_q, bit_cnt_d;
  logic [2:0]             bytes_left_q, bytes_left_d, bl_dec;
  op_e                    op_q, op_d, new_op;
  logic                   rise, fall, short_pulse, bits_full, code_full;
  span_t                  now_span, low_span, field_span;

  assign rise        = acc_i & clock_level_i & ~prev_clk_q;
  assign fall        = acc_i & ~clock_level_i & prev_clk_q;
  assign pulse_len   = now_q - low_start_q;
  assign short_pulse = pulse_len < COUNT_WIDTH'(limit_i);
  assign bits_full   = bit_cnt_q >= 4'(BYTE_BITS);
  assign code_full   = bit_cnt_q >= 4'(CODE_BITS);
  assign bl_dec      = bytes_left_q - 3'd1;
  assign new_op      = op_e'(shift_q[1:0]);
  assign now_span    = to_span(64'(now_q));
  assign low_span    = to_span(64'(low_start_q));
  assign field_span  = to_span(64'(field_start_q));

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_HUNT: if (rise && short_pulse && daf_q && data_level_i) phase_d = PH_SYNC;
      PH_SYNC: if (fall) phase_d = PH_INS;
      PH_INS: begin
        if (fall && code_full) begin
          unique case (new_op)
            OP_RD_DATA, OP_WR_DATA: phase_d = PH_LEN;
            OP_RD_ADDR:             phase_d = PH_RA_TURN;
            OP_WR_ADDR:             phase_d = PH_WBYTE;
            default:                phase_d = PH_HUNT;
          endcase
        end
      end
      PH_LEN: if (fall && code_full) phase_d = (op_q == OP_RD_DATA) ? PH_WAIT_TURN : PH_WBYTE;
      PH_RA_TURN: if (rise) phase_d = PH_RBYTE;
      PH_RBYTE: begin
        if (rise && bits_full && !(op_q == OP_RD_DATA && bl_dec != 3'd0)) phase_d = PH_HUNT;
      end
      PH_WBYTE: begin
        if (fall && bits_full) begin
          if (op_q == OP_WR_ADDR)  phase_d = PH_STOP_RISE;
          else if (bl_dec == 3'd0) phase_d = PH_WAIT_TURN;
        end
      end
      PH_WAIT_TURN: if (rise) phase_d = PH_WAIT_POLL;
      PH_WAIT_POLL: if (fall && data_level_i) phase_d = PH_WAIT_DONE;
      PH_WAIT_DONE: if (rise) phase_d = (op_q == OP_RD_DATA) ? PH_RBYTE : PH_HUNT;
      PH_STOP_RISE: if (rise) phase_d = PH_HUNT;
      default: phase_d = PH_HUNT;
    endcase
  end

  // Field registers: shifter, bit and byte counts, opcode, field origin.
  always_comb begin
    low_start_d   = low_start_q;
    daf_d         = daf_q;
    field_start_d = field_start_q;
    shift_d       = shift_q;
    bit_cnt_d     = bit_cnt_q;
    bytes_left_d  = bytes_left_q;
    op_d          = op_q;
    unique case (phase_q)
      PH_HUNT: begin
        if (fall) begin
          low_start_d = now_q;
          daf_d       = data_level_i;
        end
      end
      PH_SYNC: begin
        if (fall) begin
          field_start_d = now_q;
          shift_d       = '0;
          bit_cnt_d     = '0;
        end
      end
      PH_INS, PH_LEN: begin
        if (rise && !code_full) begin
          shift_d   = {shift_q[6:0], data_level_i};
          bit_cnt_d = bit_cnt_q + 4'd1;
        end else if (fall && code_full) begin
          field_start_d = now_q;
          shift_d       = '0;
          bit_cnt_d     = '0;
          if (phase_q == PH_INS) begin
            op_d = new_op;
            if (new_op == OP_RD_ADDR || new_op == OP_WR_ADDR) bytes_left_d = 3'd1;
          end else begin
            bytes_left_d = {1'b0, shift_q[1:0]} + 3'd1;
          end
        end
      end
      PH_RA_TURN: begin
        if (rise) begin
          shift_d   = '0;
          bit_cnt_d = '0;
        end
      end
      PH_RBYTE: begin
        if (rise && bits_full) begin
          bytes_left_d = bl_dec;
          if (op_q == OP_RD_DATA && bl_dec != 3'd0) begin
            field_start_d = now_q;
            shift_d       = '0;
            bit_cnt_d     = '0;
          end
        end else if (fall && !bits_full) begin
          shift_d   = {data_level_i, shift_q[7:1]};
          bit_cnt_d = bit_cnt_q + 4'd1;
        end
      end
      PH_WBYTE: begin
        if (rise && !bits_full) begin
          shift_d   = {data_level_i, shift_q[7:1]};
          bit_cnt_d = bit_cnt_q + 4'd1;
        end else if (fall && bits_full && op_q != OP_WR_ADDR) begin
          bytes_left_d  = bl_dec;
          field_start_d = now_q;
          shift_d       = '0;
          bit_cnt_d     = '0;
        end
      end
      PH_WAIT_DONE: begin
        if (rise && op_q == OP_RD_DATA) begin
          field_start_d = now_q;
          shift_d       = '0;
          bit_cnt_d     = '0;
        end
      end
      default: ;
    endcase
  end

  // Result words for this sample.
  always_comb begin
    push_o.count = 2'd0;
    push_o.res_a = '{kind: KIND_START, value: 8'd0, operation: op_q,
                     first_sample: now_span, final_sample: now_span, last: 1'b0};
    push_o.res_b = '{kind: KIND_STOP, value: 8'd0, operation: op_q,
                     first_sample: now_span, final_sample: now_span, last: 1'b1};
    unique case (phase_q)
      PH_HUNT: begin
        if (rise && short_pulse) begin
          push_o.count              = 2'd1;
          push_o.res_a.first_sample = low_span;
          push_o.res_a.final_sample = low_span;
        end
      end
      PH_INS: begin
        if (fall && code_full) begin
          push_o.count              = 2'd1;
          push_o.res_a.kind         = KIND_INSTR;
          push_o.res_a.value        = 8'(shift_q[1:0]);
          push_o.res_a.operation    = new_op;
          push_o.res_a.first_sample = field_span;
        end
      end
      PH_LEN: begin
        if (fall && code_full) begin
          push_o.count              = 2'd1;
          push_o.res_a.kind         = KIND_LENGTH;
          push_o.res_a.value        = 8'(shift_q[1:0]);
          push_o.res_a.first_sample = field_span;
        end
      end
      PH_RBYTE: begin
        if (rise && bits_full) begin
          push_o.count              = (op_q == OP_RD_DATA && bl_dec != 3'd0) ? 2'd1 : 2'd2;
          push_o.res_a.kind         = KIND_BYTE;
          push_o.res_a.value        = shift_q;
          push_o.res_a.first_sample = field_span;
        end
      end
      PH_WBYTE: begin
        if (fall && bits_full) begin
          push_o.count              = 2'd1;
          push_o.res_a.kind         = KIND_BYTE;
          push_o.res_a.value        = shift_q;
          push_o.res_a.first_sample = field_span;
        end
      end
      PH_WAIT_DONE: begin
        if (rise) begin
          push_o.count              = (op_q == OP_RD_DATA) ? 2'd1 : 2'd2;
          push_o.res_a.kind         = KIND_WAIT_END;
          push_o.res_a.first_sample = field_span;
        end
      end
      PH_STOP_RISE: begin
        if (rise) begin
          push_o.count      = 2'd1;
          push_o.res_a.kind = KIND_STOP;
        end
      end
      default: ;
    endcase
    push_o.res_a.last = (push_o.count == 2'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q         <= '0;
      prev_clk_q    <= 1'b1;
      phase_q       <= PH_HUNT;
      low_start_q   <= '0;
      daf_q         <= 1'b0;
      field_start_q <= '0;
      shift_q       <= '0;
      bit_cnt_q     <= '0;
      bytes_left_q  <= '0;
      op_q          <= OP_RD_DATA;
    end else if (acc_i) begin
      now_q         <= now_q + COUNT_WIDTH'(1);
      prev_clk_q    <= clock_level_i;
      phase_q       <= phase_d;
      low_start_q   <= low_start_d;
      daf_q         <= daf_d;
      field_start_q <= field_start_d;
      shift_q       <= shift_d;
      bit_cnt_q     <= bit_cnt_d;
      bytes_left_q  <= bytes_left_d;
      op_q          <= op_d;
    end
  end

endmodule

>>> rtl/core/twdb_queue.sv
// Result word queue between front end and output stage: two pushes, one pop a cycle.
module twdb_queue
  import twdb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  push_t       push_i,
  input  logic        pop_i,
  output result_t     head_o,
  output queue_stat_t stat_o
);

  result_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  assign wr_ptr_d = wr_ptr_q + QPTR_W'(push_i.count);
  assign rd_ptr_d = rd_ptr_q + QPTR_W'(pop_i);
  assign cnt_d    = cnt_q + QCNT_W'(push_i.count) - QCNT_W'(pop_i);

  assign head_o           = mem_q[rd_ptr_q];
  assign stat_o.not_empty = (cnt_q != '0);
  assign stat_o.room      = (cnt_q <= QCNT_W'(QUEUE_DEPTH - 2));
  assign stat_o.count     = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_ptr_q] <= push_i.res_a;
    if (push_i.count == 2'd2) mem_q[wr_ptr_q + QPTR_W'(1)] <= push_i.res_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> rtl/core/twdb_back.sv
// Output stage: registers the queue head onto the result channel.
module twdb_back
  import twdb_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  result_t         head_i,
  input  logic            head_valid_i,
  output logic            pop_o,
  result_if.source        res_o
);

  logic    valid_q;
  result_t data_q;

  // Load a new word when the register is empty or its word is being taken.
  assign pop_o = head_valid_i & (~valid_q | res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (~valid_q | res_o.ready) begin
      valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) data_q <= head_i;
  end

  assign res_o.valid        = valid_q;
  assign res_o.kind         = data_q.kind;
  assign res_o.value        = data_q.value;
  assign res_o.operation    = data_q.operation;
  assign res_o.first_sample = data_q.first_sample;
  assign res_o.final_sample = data_q.final_sample;
  assign res_o.last         = data_q.last;

endmodule

>>> rtl/core/two_wire_debug_bus_decoder.sv
// Top level of the two-wire debug bus decoder: passive monitor of clock/data samples.
//
//   channel    dir  handshake       word
//   sample_i   in   valid/ready     clock_level, data_level (one bus sample)
//   result_o   out  valid/ready     kind, value, operation, first/final_sample, last
//   cfg        in   cfg_we_i only   cfg_data_i -> short pulse limit
//
// One sample is taken per cycle while sample_i.ready is high; its zero, one or two
// result words are queued at the accepting edge, then registered onto result_o once free.
// sample_i.ready drops while the four-entry queue has fewer than two free
// entries, so a stalled result_o backs up into the input once three words wait behind it.
// Reset clears all control state, loads the limit with 40 and empties the queue;
// no clearing pass is needed, the block takes samples right after reset.
`include "two_wire_debug_bus_decoder_defines.svh"

module two_wire_debug_bus_decoder
  import twdb_pkg::*;
#(
  parameter int COUNT_WIDTH = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  sample_if.sink             sample_i,
  result_if.source           result_o,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_data_i
);

  logic [LIMIT_W-1:0] limit_q;
  logic               accept;
  push_t              push;
  result_t            head;
  queue_stat_t        stat;
  logic               pop;

  // Short pulse limit; the user must write it only while the bus monitor is idle (unenforced).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Take a sample only when the queue can hold the worst case of two words.
  assign sample_i.ready = stat.room;
  assign accept         = sample_i.valid & sample_i.ready;

  twdb_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (accept),
    .clock_level_i(sample_i.clock_level),
    .data_level_i (sample_i.data_level),
    .limit_i      (limit_q),
    .push_o       (push)
  );

  twdb_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .pop_i (pop),
    .head_o(head),
    .stat_o(stat)
  );

  twdb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .head_valid_i(stat.not_empty),
    .pop_o       (pop),
    .res_o       (result_o)
  );

  // Queue occupancy stays within its depth.
  `TWDB_ASSERT_NOW(a_queue_bound, 1'b1, stat.count <= QCNT_W'(QUEUE_DEPTH), "queue overflow")
  // Words come only from accepted samples.
  `TWDB_ASSERT_NOW(a_push_on_accept, push.count != 2'd0, accept, "word without a sample")
  // With two words the first never carries the last flag.
  `TWDB_ASSERT_NOW(a_pair_last, push.count == 2'd2, !push.res_a.last, "misplaced last flag")
  // A double push leaves the queue holding words.
  `TWDB_ASSERT_NEXT(a_pair_stored, push.count == 2'd2, stat.not_empty, "pair dropped")

endmodule

>>> sim/tb_two_wire_debug_bus_decoder.sv
// Self-checking testbench of the two-wire debug bus decoder: directed table, random traffic.
module tb_two_wire_debug_bus_decoder import twdb_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // Bounds for the run: a word must be accepted on some channel at least this often,
  // the receiver's long hold-off, and the pause that lets the pipe empty.
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned SHOW_MAX    = 40;

  // How the expectation for one offered sample is formed.
  typedef enum logic [1:0] {
    EXP_PREDICT = 2'd0,  // take whatever the decoder model produces
    EXP_NONE    = 2'd1,  // typed in: no word
    EXP_ONE     = 2'd2   // typed in: exactly the one word of the row
  } chk_e;

  typedef struct packed {
    logic    c;
    logic    d;
    chk_e    chk;
    result_t word;
  } dir_row_t;

  typedef struct packed {
    chk_e    chk;
    result_t word;
  } sample_tag_t;

  localparam result_t NO_WORD = '0;

  // Opening sequence right after reset, one bus sample per row.
  // Clock low on the first sample is a falling edge. Then a short pulse with data low at
  // the fall (start marker, no sync), one with data low at the rise (marker, no sync),
  // a clean start, a read-address instruction, and an all-ones byte read on falling
  // edges that closes with the byte and the stop marker on the same rising edge.
  localparam dir_row_t DIRECTED [29] = '{
    '{1'b0, 1'b0, EXP_NONE,    NO_WORD},
    '{1'b1, 1'b1, EXP_ONE,     '{KIND_START, 8'h00, OP_RD_DATA, 48'd0, 48'd0, 1'b1}},
    '{1'b0, 1'b1, EXP_NONE,    NO_WORD},
    '{1'b1, 1'b0, EXP_ONE,     '{KIND_START, 8'h00, OP_RD_DATA, 48'd2, 48'd2, 1'b1}},
    '{1'b0, 1'b1, EXP_NONE,    NO_WORD},
    '{1'b1, 1'b1, EXP_ONE,     '{KIND_START, 8'h00, OP_RD_DATA, 48'd4, 48'd4, 1'b1}},
    '{1'b1, 1'b0, EXP_NONE,    NO_WORD},
    '{1'b0, 1'b0, EXP_PREDICT, NO_WORD},
    '{1'b1, 1'b1, EXP_PREDICT, NO_WORD},
    '{1'b0, 1'b0, EXP_PREDICT, NO_WORD},
    '{1'b1, 1'b0, EXP_PREDICT, NO_WORD},
    '{1'b0, 1'b1, EXP_ONE,     '{KIND_INSTR, 8'h02, OP_RD_ADDR, 48'd7, 48'd11, 1'b1}},
    '{1'b1, 1'b0, EXP_PREDICT, NO_WORD},
    '{1'b0, 1'b1, EXP_PREDICT, NO_WORD},
    '{1'b1, 1'b0, EXP_PREDICT, NO_WORD},
    '{1'b0, 1'b1, EXP_PREDICT, NO_WORD},
    '{1'b1, 1'b0, EXP_PREDICT, NO_WORD},
    '{1'b0, 1'b1, EXP_PREDICT, NO_WORD},
    '{1'b1, 1'b0, EXP_PREDICT, NO_WORD},
    '{1'b0, 1'b1, EXP_PREDICT, NO_WORD},
    '{1'b1, 1'b0, EXP_PREDICT, NO_WORD},
    '{1'b0, 1'b1, EXP_PREDICT, NO_WORD},
    '{1'b1, 1'b0, EXP_PREDICT, NO_WORD},
    '{1'b0, 1'b1, EXP_PREDICT, NO_WORD},
    '{1'b1, 1'b0, EXP_PREDICT, NO_WORD},
    '{1'b0, 1'b1, EXP_PREDICT, NO_WORD},
    '{1'b1, 1'b0, EXP_PREDICT, NO_WORD},
    '{1'b0, 1'b1, EXP_PREDICT, NO_WORD},
    '{1'b1, 1'b0, EXP_PREDICT, NO_WORD}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [LIMIT_W-1:0] cfg_data;

  sample_if smp_bus ();
  result_if res_bus ();

  two_wire_debug_bus_decoder uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .sample_i   (smp_bus),
    .result_o   (res_bus),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Decoder model: its own copy of the limit and of the bus state.
  // ---------------------------------------------------------------------------
  logic [LIMIT_W-1:0] short_lim  = LIMIT_RESET;
  span_t              smp_idx    = '0;
  logic               clk_prev   = 1'b1;
  phase_e             bus_phase  = PH_HUNT;
  span_t              low_at     = '0;
  logic               data_fell  = 1'b0;
  logic [7:0]         shreg      = '0;
  int unsigned        nbits      = 0;
  logic [2:0]         bytes_left = '0;
  op_e                cur_op     = OP_RD_DATA;
  span_t              field_at   = '0;

  // Words caused by the sample just decoded.
  result_t step_words [2];
  int      step_n;

  result_t     expected_words [$];
  sample_tag_t sample_tags [$];

  int unsigned fail_count   = 0;
  int unsigned sent_cnt     = 0;
  int unsigned burst_left   = 0;
  int unsigned quiet_cycles = 0;
  logic        bursty       = 1'b1;
  logic        hold_req     = 1'b0;
  logic        hold_done    = 1'b0;

  function automatic void add_word(kind_e k, logic [7:0] v, span_t a, span_t b);
    step_words[step_n] = '{k, v, cur_op, a, b, 1'b0};
    step_n++;
  endfunction

  function automatic void open_field(span_t now);
    field_at = now;
    shreg    = '0;
    nbits    = 0;
  endfunction

  // Advance the model by one bus sample and leave its words in step_words.
  function automatic void decode_sample(logic c, logic d);
    span_t now;
    now    = smp_idx;
    step_n = 0;
    if (c && !clk_prev) begin
      // rising clock edge
      case (bus_phase)
        PH_HUNT: begin
          // every short low pulse gives a marker; only data high at both edges syncs
          if (now - low_at < {32'd0, short_lim}) begin
            add_word(KIND_START, 8'h00, low_at, low_at);
            if (data_fell && d) bus_phase = PH_SYNC;
          end
        end
        PH_INS, PH_LEN: begin
          if (nbits < 2) begin
            shreg = {shreg[6:0], d};
            nbits++;
          end
        end
        PH_RA_TURN: begin
          shreg     = '0;
          nbits     = 0;
          bus_phase = PH_RBYTE;
        end
        PH_RBYTE: begin
          if (nbits >= 8) begin
            add_word(KIND_BYTE, shreg, field_at, now);
            bytes_left = bytes_left - 3'd1;
            if (cur_op == OP_RD_DATA && bytes_left != 3'd0) begin
              open_field(now);
            end else begin
              add_word(KIND_STOP, 8'h00, now, now);
              bus_phase = PH_HUNT;
            end
          end
        end
        PH_WBYTE: begin
          if (nbits < 8) begin
            shreg = {d, shreg[7:1]};
            nbits++;
          end
        end
        PH_WAIT_TURN: bus_phase = PH_WAIT_POLL;
        PH_WAIT_DONE: begin
          add_word(KIND_WAIT_END, 8'h00, field_at, now);
          if (cur_op == OP_RD_DATA) begin
            open_field(now);
            bus_phase = PH_RBYTE;
          end else begin
            add_word(KIND_STOP, 8'h00, now, now);
            bus_phase = PH_HUNT;
          end
        end
        PH_STOP_RISE: begin
          add_word(KIND_STOP, 8'h00, now, now);
          bus_phase = PH_HUNT;
        end
        default: ;
      endcase
    end else if (!c && clk_prev) begin
      // falling clock edge
      case (bus_phase)
        PH_HUNT: begin
          low_at    = now;
          data_fell = d;
        end
        PH_SYNC: begin
          open_field(now);
          bus_phase = PH_INS;
        end
        PH_INS: begin
          if (nbits >= 2) begin
            cur_op = op_e'(shreg[1:0]);
            add_word(KIND_INSTR, {6'd0, shreg[1:0]}, field_at, now);
            open_field(now);
            if (cur_op == OP_RD_DATA || cur_op == OP_WR_DATA) begin
              bus_phase = PH_LEN;
            end else begin
              bytes_left = 3'd1;
              bus_phase  = (cur_op == OP_RD_ADDR) ? PH_RA_TURN : PH_WBYTE;
            end
          end
        end
        PH_LEN: begin
          if (nbits >= 2) begin
            add_word(KIND_LENGTH, {6'd0, shreg[1:0]}, field_at, now);
            bytes_left = {1'b0, shreg[1:0]} + 3'd1;
            open_field(now);
            bus_phase = (cur_op == OP_RD_DATA) ? PH_WAIT_TURN : PH_WBYTE;
          end
        end
        PH_RBYTE: begin
          if (nbits < 8) begin
            shreg = {d, shreg[7:1]};
            nbits++;
          end
        end
        PH_WBYTE: begin
          if (nbits >= 8) begin
            add_word(KIND_BYTE, shreg, field_at, now);
            if (cur_op == OP_WR_ADDR) begin
              bus_phase = PH_STOP_RISE;
            end else begin
              bytes_left = bytes_left - 3'd1;
              open_field(now);
              if (bytes_left == 3'd0) bus_phase = PH_WAIT_TURN;
            end
          end
        end
        PH_WAIT_POLL: begin
          if (d) bus_phase = PH_WAIT_DONE;
        end
        default: ;
      endcase
    end
    if (step_n > 0) step_words[step_n-1].last = 1'b1;
    clk_prev = c;
    smp_idx  = smp_idx + 1'b1;
  endfunction

  function automatic void cmp_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= SHOW_MAX)
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted sample, check every accepted result word,
  // and watch for a stuck pipe.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    sample_tag_t tag;
    result_t     want;
    logic        moved;
    moved = 1'b0;
    if (smp_bus.valid && smp_bus.ready) begin
      moved = 1'b1;
      tag   = sample_tags.pop_front();
      decode_sample(smp_bus.clock_level, smp_bus.data_level);
      // typed rows override the model's words but the model still advances
      case (tag.chk)
        EXP_ONE: expected_words.push_back(tag.word);
        EXP_NONE: ;
        default: begin
          for (int i = 0; i < step_n; i++) expected_words.push_back(step_words[i]);
        end
      endcase
    end
    if (res_bus.valid && res_bus.ready) begin
      moved = 1'b1;
      if (expected_words.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_MAX)
          $display("%0t ns: word with nothing expected, expected none, got kind %0d value %0h",
                   $time, res_bus.kind, res_bus.value);
      end else begin
        want = expected_words.pop_front();
        cmp_field("kind", 64'(want.kind), 64'(res_bus.kind));
        cmp_field("value", 64'(want.value), 64'(res_bus.value));
        cmp_field("operation", 64'(want.operation), 64'(res_bus.operation));
        cmp_field("first_sample", 64'(want.first_sample), 64'(res_bus.first_sample));
        cmp_field("final_sample", 64'(want.final_sample), 64'(res_bus.final_sample));
        cmp_field("last", 64'(want.last), 64'(res_bus.last));
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no word moved for %0d cycles, %0d words still expected",
               $time, QUIET_LIMIT, expected_words.size());
      $display("tb_two_wire_debug_bus_decoder: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: stall on a pattern that steps through four ready modes, and hold off
  // once for a long stretch so the queue fills and the sample input backs up.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned tick;
    tick          = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        res_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        case ((tick / 256) % 4)
          0: res_bus.ready <= 1'b1;
          1: res_bus.ready <= 1'($urandom);
          2: res_bus.ready <= ($urandom_range(0, 9) != 0);
          default: res_bus.ready <= ((tick % 7) >= 3);
        endcase
        tick++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sample side. Every task is entered and left at a falling edge.
  // ---------------------------------------------------------------------------

  // Offer one bus sample and hold it until the decoder takes it.
  task automatic send_sample(input logic c, input logic d,
                             input chk_e chk = EXP_PREDICT, input result_t word = '0);
    int unsigned gap;
    if (burst_left == 0) begin
      // open a new burst, often after a gap; never after one when idling is off for this phase
      burst_left = $urandom_range(1, 20);
      gap = (!bursty || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        smp_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    sample_tags.push_back('{chk, word});
    smp_bus.valid       <= 1'b1;
    smp_bus.clock_level <= c;
    smp_bus.data_level  <= d;
    @(posedge clk);
    while (!smp_bus.ready) @(posedge clk);
    @(negedge clk);
    sent_cnt++;
  endtask

  // Hold the clock line at one level; data is chosen on the edge sample, random after it.
  task automatic send_level(input logic c, input int unsigned n, input logic d_edge);
    send_sample(c, d_edge);
    repeat (n - 1) send_sample(c, 1'($urandom));
  endtask

  // Bus half-period in samples: mostly short, now and then long enough to defeat the limit.
  function automatic int unsigned half_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(4, 50) : $urandom_range(1, 3);
  endfunction

  // One transfer: a start strobe, then bus cycles with random data until the decoder
  // is back to hunting. Some strobes are too long or carry low data; some transfers
  // are dropped part way and left for the next strobe to run into.
  task automatic send_packet();
    int unsigned lo, top, cap, cyc;
    logic        clean;
    clean = ($urandom_range(0, 9) != 0);
    top   = (short_lim > 7) ? 6 : ((short_lim > 1) ? short_lim - 1 : 1);
    lo    = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 60) : $urandom_range(1, top);
    send_level(1'b0, lo, clean | 1'($urandom));
    send_level(1'b1, $urandom_range(1, 3), clean | 1'($urandom));
    cap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12) : 80;
    cyc = 0;
    while (bus_phase != PH_HUNT && cyc < cap) begin
      send_level(1'b0, half_len(), 1'($urandom));
      send_level(1'b1, half_len(), 1'($urandom));
      cyc++;
    end
  endtask

  // Mostly clean transfers, with bursts of line noise in between.
  task automatic run_traffic(input int unsigned n);
    int unsigned target;
    target = sent_cnt + n;
    while (sent_cnt < target) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(5, 30)) send_sample(1'($urandom), 1'($urandom));
      end else begin
        send_packet();
      end
    end
  endtask

  // Drop valid, wait for every expected word, then let the pipe settle.
  task automatic drain();
    smp_bus.valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    short_lim = v;
  endtask

  initial begin : stimulus
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_data            = '0;
    smp_bus.valid       = 1'b0;
    smp_bus.clock_level = 1'b1;
    smp_bus.data_level  = 1'b1;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening, still on the reset limit.
    foreach (DIRECTED[i])
      send_sample(DIRECTED[i].c, DIRECTED[i].d, DIRECTED[i].chk, DIRECTED[i].word);

    // Reset limit with bursty input; the receiver takes its long hold-off here.
    hold_req = 1'b1;
    run_traffic(150);

    // Widest limit, no idling on the input side.
    bursty = 1'b0;
    set_limit('1);
    run_traffic(150);
    bursty = 1'b1;

    // Limit one: no pulse can be that short. Limit zero: nothing is short at all.
    set_limit(16'd1);
    run_traffic(40);
    set_limit(16'd0);
    run_traffic(40);

    // Tight limit: only single-sample low pulses start a transfer.
    set_limit(16'd2);
    run_traffic(150);

    set_limit(16'($urandom_range(3, 120)));
    run_traffic(200);
    set_limit(16'($urandom_range(121, 65534)));
    run_traffic(150);

    drain();
    if (fail_count == 0) begin
      $display("tb_two_wire_debug_bus_decoder: PASS");
    end else begin
      $display("tb_two_wire_debug_bus_decoder: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/twdb_pkg.sv
rtl/core/twdb_if.sv
rtl/core/twdb_front.sv
rtl/core/twdb_queue.sv
rtl/core/twdb_back.sv
rtl/core/two_wire_debug_bus_decoder.sv
sim/tb_two_wire_debug_bus_decoder.sv
